[rtl/core/sqr_pkg.sv]
`timescale 1ns / 1ps

package sqr_pkg;

   // Default configuration handed to the top level.
   localparam int CLASS_BITS_DEF  = 5;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Field widths fixed by the stream format.
   localparam int CHAR_W   = 8;
   localparam int CLASS_W  = 5;
   localparam int STATUS_W = 2;

   // Lexical class codes, fixed header encoding.
   localparam logic [CLASS_W-1:0] CL_SPACE  = 5'd1;
   localparam logic [CLASS_W-1:0] CL_BSLASH = 5'd2;
   localparam logic [CLASS_W-1:0] CL_AND    = 5'd4;
   localparam logic [CLASS_W-1:0] CL_DQUOTE = 5'd5;
   localparam logic [CLASS_W-1:0] CL_SQUOTE = 5'd6;
   localparam logic [CLASS_W-1:0] CL_PIPE   = 5'd15;
   localparam logic [CLASS_W-1:0] CL_ENTER  = 5'd20;
   localparam logic [CLASS_W-1:0] CL_GLUE   = 5'd22;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // Quote mode codes.
   localparam logic [1:0] QM_NONE   = 2'd0;
   localparam logic [1:0] QM_SINGLE = 2'd1;
   localparam logic [1:0] QM_DOUBLE = 2'd2;

   // Operator tracking codes.
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_AMP  = 2'd1;
   localparam logic [1:0] OP_SEEN = 2'd2;

   // End status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OPEN_SQ = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OPEN_DQ = 2'd2;

   // One classified beat, as passed from the front end to the back end.
   typedef struct packed {
      logic                has_byte;
      logic                last;
      logic [CHAR_W-1:0]   data_byte;
      logic [CLASS_W-1:0]  cls;
      logic [STATUS_W-1:0] status;
   } sqr_entry_type;

   localparam int ENTRY_W = $bits(sqr_entry_type);

endpackage

[rtl/core/sqr_if.sv]
`timescale 1ns / 1ps

interface sqr_req_if
   import sqr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  in_char;
   logic [CLASS_W-1:0] in_class;
   logic               in_last;

   modport source (output valid, output in_char, output in_class, output in_last,
                   input ready);
   modport sink   (input valid, input in_char, input in_class, input in_last,
                   output ready);
endinterface

interface sqr_rsp_if
   import sqr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   out_char;
   logic [CLASS_W-1:0]  out_class;
   logic                is_end;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_char, output out_class, output is_end,
                   output status, input ready);
   modport sink   (input valid, input out_char, input out_class, input is_end,
                   input status, output ready);
endinterface

[rtl/core/sqr_front.sv]
`timescale 1ns / 1ps

module sqr_front
   import sqr_pkg::*;
#(
   parameter int ClassBits = CLASS_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sqr_req_if.sink       req_chan,
   input  logic          push_ready,
   output logic          push_valid,
   output sqr_entry_type push_entry
);

   localparam logic [CLASS_W-1:0] ClassMask =
      (ClassBits >= CLASS_W) ? {CLASS_W{1'b1}} : CLASS_W'((1 << ClassBits) - 1);

   logic [1:0] quote_mode_ff, quote_mode_in;
   logic       escape_ff, escape_in;
   logic [1:0] op_state_ff, op_state_in;

   logic [CLASS_W-1:0] cl;
   logic [CLASS_W-1:0] keep_cls;
   logic [CHAR_W-1:0]  keep_char;
   logic               keep;
   logic [1:0]         qm_next;
   logic               esc_next;
   logic [1:0]         op_next;
   logic               accept;

   assign cl     = req_chan.in_class & ClassMask;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = push_ready;

   // Per-character decision, one step per beat.
   always_comb begin
      qm_next   = quote_mode_ff;
      esc_next  = escape_ff;
      op_next   = op_state_ff;
      keep      = 1'b0;
      keep_char = req_chan.in_char;
      keep_cls  = cl;
      if (quote_mode_ff == QM_SINGLE) begin
         if (cl == CL_SQUOTE) begin
            qm_next = QM_NONE;
         end else begin
            keep = 1'b1;
         end
      end else if (escape_ff) begin
         esc_next = 1'b0;
         op_next  = OP_NONE;
         if (cl != CL_ENTER) begin
            keep = 1'b1;
            if (quote_mode_ff == QM_DOUBLE && cl == CL_SPACE) begin
               keep_cls = CL_GLUE;
            end
         end
      end else if (cl == CL_BSLASH) begin
         esc_next = 1'b1;
         op_next  = OP_NONE;
      end else if (quote_mode_ff == QM_DOUBLE) begin
         if (cl == CL_DQUOTE) begin
            qm_next = QM_NONE;
         end else begin
            keep = 1'b1;
            if (cl == CL_SPACE) begin
               keep_cls = CL_GLUE;
            end
         end
      end else if (cl == CL_SQUOTE) begin
         qm_next = QM_SINGLE;
         op_next = OP_NONE;
      end else if (cl == CL_DQUOTE) begin
         qm_next = QM_DOUBLE;
         op_next = OP_NONE;
      end else if (cl == CL_ENTER) begin
         // A newline after an operator, with only spaces between, continues the line as a space.
         if (op_state_ff == OP_SEEN) begin
            keep      = 1'b1;
            keep_char = CHAR_SPACE;
            keep_cls  = CL_SPACE;
         end
         op_next = OP_NONE;
      end else begin
         keep = 1'b1;
         if (cl == CL_PIPE) begin
            op_next = OP_SEEN;
         end else if (cl == CL_AND) begin
            op_next = (op_state_ff == OP_AMP) ? OP_SEEN : OP_AMP;
         end else if (cl == CL_SPACE) begin
            op_next = (op_state_ff == OP_SEEN) ? OP_SEEN : OP_NONE;
         end else begin
            op_next = OP_NONE;
         end
      end
   end

   always_comb begin
      push_entry.has_byte  = keep;
      push_entry.last      = req_chan.in_last;
      push_entry.data_byte = keep_char;
      push_entry.cls       = keep_cls & ClassMask;
      case (qm_next)
         QM_SINGLE: push_entry.status = ST_OPEN_SQ;
         QM_DOUBLE: push_entry.status = ST_OPEN_DQ;
         default:   push_entry.status = ST_OK;
      endcase
      push_valid = accept && (keep || req_chan.in_last);
   end

   always_comb begin
      quote_mode_in = quote_mode_ff;
      escape_in     = escape_ff;
      op_state_in   = op_state_ff;
      if (accept) begin
         if (req_chan.in_last) begin
            quote_mode_in = QM_NONE;
            escape_in     = 1'b0;
            op_state_in   = OP_NONE;
         end else begin
            quote_mode_in = qm_next;
            escape_in     = esc_next;
            op_state_in   = op_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_mode_ff <= QM_NONE;
         escape_ff     <= 1'b0;
         op_state_ff   <= OP_NONE;
      end else begin
         quote_mode_ff <= quote_mode_in;
         escape_ff     <= escape_in;
         op_state_ff   <= op_state_in;
      end
   end

   // A finished line leaves every piece of mode state cleared.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.in_last |=>
         quote_mode_ff == QM_NONE && !escape_ff && op_state_ff == OP_NONE)
      else $error("mode state not cleared after line end");

   // Inside single quotes no escape can be waiting.
   assert property (@(posedge clock) disable iff (reset)
      quote_mode_ff == QM_SINGLE |-> !escape_ff)
      else $error("escape pending inside single quotes");

   // An escape always clears the operator tracking.
   assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> op_state_ff == OP_NONE)
      else $error("operator state live while escape pending");

endmodule

[rtl/core/sqr_fifo.sv]
`timescale 1ns / 1ps

module sqr_fifo
   import sqr_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  sqr_entry_type push_entry,
   output logic          push_ready,
   output logic          head_valid,
   output sqr_entry_type head_entry,
   input  logic          pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] Full = CntW'(Depth);

   sqr_entry_type      entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != Full);
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> !do_push)
      else $error("write into full queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");

endmodule

[rtl/core/sqr_back.sv]
`timescale 1ns / 1ps

module sqr_back
   import sqr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  sqr_entry_type head_entry,
   output logic          pop,
   sqr_rsp_if.source     rsp_chan
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   out_char_ff, out_char_in;
   logic [CLASS_W-1:0]  out_class_ff, out_class_in;
   logic                is_end_ff, is_end_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                end_phase_ff, end_phase_in;
   logic                load;

   assign load = !rsp_valid_ff || rsp_chan.ready;

   // An entry with a kept byte and a line end is sent as two beats:
   // the byte first, then the end status.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_char_in  = out_char_ff;
      out_class_in = out_class_ff;
      is_end_in    = is_end_ff;
      status_in    = status_ff;
      end_phase_in = end_phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head_entry.has_byte && !end_phase_ff) begin
               out_char_in  = head_entry.data_byte;
               out_class_in = head_entry.cls;
               is_end_in    = 1'b0;
               status_in    = ST_OK;
               end_phase_in = head_entry.last;
               pop          = !head_entry.last;
            end else begin
               out_char_in  = '0;
               out_class_in = '0;
               is_end_in    = 1'b1;
               status_in    = head_entry.status;
               end_phase_in = 1'b0;
               pop          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         end_phase_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         end_phase_ff <= end_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_class_ff <= out_class_in;
      is_end_ff    <= is_end_in;
      status_ff    <= status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = out_char_ff;
   assign rsp_chan.out_class = out_class_ff;
   assign rsp_chan.is_end    = is_end_ff;
   assign rsp_chan.status    = status_ff;

   // The end half of a split entry keeps that entry at the queue head.
   assert property (@(posedge clock) disable iff (reset)
      end_phase_ff |-> head_valid && head_entry.last && head_entry.has_byte)
      else $error("end phase without its entry");

   // A byte beat carries no status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !is_end_ff |-> status_ff == ST_OK)
      else $error("status on a byte beat");

   // Entering the end phase means the byte beat was just loaded.
   assert property (@(posedge clock) disable iff (reset)
      $rose(end_phase_ff) |-> rsp_valid_ff && !is_end_ff)
      else $error("end phase without preceding byte beat");

endmodule

[rtl/core/shell_quote_removal_stream.sv]
`timescale 1ns / 1ps

// Quote removal on a command line stream. Each request beat carries one byte
// of the line, its lexical class code and a flag for the last byte. Quote
// characters are removed, a backslash escapes the byte after it (and a
// backslash-newline pair vanishes), spaces inside double quotes are reclassed
// as glue, and an unquoted newline is dropped unless it follows a pipe, a
// double pipe or a double ampersand with only spaces between, where it turns
// into a space. The last byte of a line also produces an end beat whose
// status tells ok, an open single quote or an open double quote; that beat
// has is_end set and zero byte and class, and it follows the byte beat of the
// same input when there is one. Mode state returns to its reset values after
// every line end. The front end decides each byte combinationally and accepts
// a new request beat every cycle as long as the small queue toward the back
// end has room; the back end registers the response and sends one beat per
// cycle while the receiver is ready. A kept byte gives one response beat and
// a dropped one none; a last byte also gives its end beat, after its byte
// beat when that is kept, and the back end's single output register sends
// the two one after the other. ClassBits masks the incoming class code, and
// the outgoing one, to that many low bits.

module shell_quote_removal_stream
   import sqr_pkg::*;
#(
   parameter int ClassBits  = CLASS_BITS_DEF,
   parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sqr_req_if.sink   req_chan,
   sqr_rsp_if.source rsp_chan
);

   // Classified entries flow from the front end through the queue.
   logic          push_valid;
   logic          push_ready;
   sqr_entry_type push_entry;
   logic          head_valid;
   sqr_entry_type head_entry;
   logic          pop;

   sqr_front #(
      .ClassBits (ClassBits)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   sqr_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   sqr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
